FILE: rtl/qkce_pkg.sv
package qkce_pkg;

    // Default sizes handed to the top level parameters.
    localparam int RING_DEPTH_DEF = 16;
    localparam int TIMER_BITS_DEF = 16;

    // Operation codes carried by an input word.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POP  = 2'd1,
        OP_ZERO = 2'd2
    } opcode_t;

    // Event codes stored in the ring and returned by a pop.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_CW     = 3'd1;
    localparam logic [2:0] EV_CCW    = 3'd2;
    localparam logic [2:0] EV_SHORT  = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;
    localparam logic [2:0] EV_DOUBLE = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STEP_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_KEY_DEBOUNCE     = 3'd1;
    localparam logic [2:0] CFG_STEPS_PER_DETENT = 3'd2;
    localparam logic [2:0] CFG_LONG_PRESS       = 3'd3;
    localparam logic [2:0] CFG_SHORT_PRESS_MAX  = 3'd4;
    localparam logic [2:0] CFG_DOUBLE_GAP       = 3'd5;

    typedef enum logic [2:0] {
        BS_IDLE        = 3'd0,
        BS_DEB_DOWN    = 3'd1,
        BS_PRESSED     = 3'd2,
        BS_DEB_UP      = 3'd3,
        BS_WAIT_DOUBLE = 3'd4
    } btn_state_t;

    typedef struct packed {
        logic [3:0]  step_debounce;
        logic [3:0]  key_debounce;
        logic [2:0]  steps_per_detent;
        logic [15:0] long_press_ticks;
        logic [15:0] short_press_max_ticks;
        logic [15:0] double_gap_ticks;
    } cfg_t;

    // One classified word as it waits between the front and the back.
    typedef struct packed {
        logic       tick;
        logic       pop;
        logic       zero;
        logic [2:0] pins;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } ev_req_t;

    typedef struct packed {
        logic move;
        logic up;
    } qdir_t;

    // Clockwise order of the phase value A*2+B is 00, 01, 11, 10.
    function automatic qdir_t quad_dir(input logic [1:0] prev, input logic [1:0] cur);
        qdir_t d;
        d = '{move: 1'b0, up: 1'b0};
        case ({prev, cur})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: d = '{move: 1'b1, up: 1'b1};
            4'b0010, 4'b1011, 4'b1101, 4'b0100: d = '{move: 1'b1, up: 1'b0};
            default: d = '{move: 1'b0, up: 1'b0};
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/qkce_front.sv
module qkce_front import qkce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [2:0] s_pins,
    output logic       q_valid,
    output cmd_t       q_cmd,
    input  logic       q_take
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_in;
    logic       push;

    // Decode the opcode once so the back only sees flags.
    always_comb begin
        cmd_in = '{tick: 1'b0, pop: 1'b0, zero: 1'b0, pins: s_pins};
        case (s_opcode)
            OP_TICK: cmd_in.tick = 1'b1;
            OP_POP:  cmd_in.pop  = 1'b1;
            OP_ZERO: cmd_in.zero = 1'b1;
            default: cmd_in.tick = 1'b0;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: rtl/qkce_quad.sv
module qkce_quad import qkce_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick_en,
    input  logic               zero_en,
    input  logic [1:0]         phases,
    input  cfg_t               cfg,
    output ev_req_t            ev,
    output logic signed [31:0] position
);

    logic [3:0]         step_cnt_reg, step_cnt_next;
    logic [1:0]         stable_reg, stable_next;
    logic signed [3:0]  accum_reg, accum_next;
    logic [31:0]        pos_reg, pos_next;
    qdir_t              dir;
    logic [4:0]         cnt_inc;
    logic [4:0]         deb_ext;
    logic [2:0]         spd;
    logic signed [4:0]  spd_s;
    logic signed [4:0]  accum_step;

    assign dir     = quad_dir(stable_reg, phases);
    assign cnt_inc = {1'b0, step_cnt_reg} + 5'd1;
    assign deb_ext = {1'b0, cfg.step_debounce};
    assign spd     = (cfg.steps_per_detent == 3'd0) ? 3'd1 : cfg.steps_per_detent;
    assign spd_s   = $signed({2'b00, spd});
    assign accum_step = dir.up ? ({accum_reg[3], accum_reg} + 5'sd1)
                               : ({accum_reg[3], accum_reg} - 5'sd1);

    always_comb begin
        step_cnt_next = step_cnt_reg;
        stable_next   = stable_reg;
        accum_next    = accum_reg;
        pos_next      = pos_reg;
        ev            = '{valid: 1'b0, code: EV_NONE};
        if (tick_en) begin
            if (!dir.move) begin
                if (phases == stable_reg) begin
                    step_cnt_next = (cnt_inc >= deb_ext) ? cfg.step_debounce : cnt_inc[3:0];
                end else begin
                    step_cnt_next = 4'd0;
                end
            end else if (cnt_inc < deb_ext) begin
                step_cnt_next = cnt_inc[3:0];
            end else begin
                pos_next      = dir.up ? (pos_reg + 32'd1) : (pos_reg - 32'd1);
                stable_next   = phases;
                step_cnt_next = 4'd0;
                if (accum_step >= spd_s) begin
                    ev         = '{valid: 1'b1, code: EV_CW};
                    accum_next = 4'(accum_step - spd_s);
                end else if (accum_step <= -spd_s) begin
                    ev         = '{valid: 1'b1, code: EV_CCW};
                    accum_next = 4'(accum_step + spd_s);
                end else begin
                    accum_next = 4'(accum_step);
                end
            end
        end
        if (zero_en) begin
            pos_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= 4'd0;
            stable_reg   <= 2'd0;
            accum_reg    <= 4'sd0;
            pos_reg      <= 32'd0;
        end else begin
            step_cnt_reg <= step_cnt_next;
            stable_reg   <= stable_next;
            accum_reg    <= accum_next;
            pos_reg      <= pos_next;
        end
    end

    assign position = $signed(pos_reg);

endmodule

FILE: rtl/qkce_button.sv
module qkce_button import qkce_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick_en,
    input  logic    key_level,
    input  cfg_t    cfg,
    output ev_req_t ev
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    btn_state_t            state_reg, state_next;
    logic [3:0]            count_reg, count_next;
    logic                  prev_reg, prev_next;
    logic [TIMER_BITS-1:0] hold_reg, hold_next;
    logic [TIMER_BITS-1:0] gap_reg, gap_next;
    logic                  wait_reg, wait_next;
    logic [TIMER_BITS-1:0] hold_inc, gap_inc;
    logic [3:0]            cnt_inc;
    logic                  edge_down;
    logic [CMP_W-1:0]      hold_c, gap_c;

    // Both timers stick at all ones.
    assign hold_inc = ((state_reg == BS_PRESSED || state_reg == BS_DEB_UP) &&
                       hold_reg != {TIMER_BITS{1'b1}}) ? hold_reg + TIMER_BITS'(1) : hold_reg;
    assign gap_inc  = (wait_reg && gap_reg != {TIMER_BITS{1'b1}}) ?
                      gap_reg + TIMER_BITS'(1) : gap_reg;
    assign hold_c   = CMP_W'(hold_inc);
    assign gap_c    = CMP_W'(gap_inc);
    assign cnt_inc  = count_reg + 4'd1;
    assign edge_down = prev_reg && !key_level;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        hold_next  = hold_reg;
        gap_next   = gap_reg;
        wait_next  = wait_reg;
        ev         = '{valid: 1'b0, code: EV_NONE};
        if (tick_en) begin
            prev_next = key_level;
            hold_next = hold_inc;
            gap_next  = gap_inc;
            case (state_reg)
                BS_IDLE: begin
                    if (edge_down) begin
                        count_next = 4'd0;
                        state_next = BS_DEB_DOWN;
                    end
                end
                BS_DEB_DOWN: begin
                    if (!key_level) begin
                        count_next = cnt_inc;
                        if (cnt_inc >= cfg.key_debounce) begin
                            hold_next  = '0;
                            state_next = BS_PRESSED;
                        end
                    end else begin
                        state_next = BS_IDLE;
                    end
                end
                BS_PRESSED: begin
                    if (key_level) begin
                        count_next = 4'd0;
                        state_next = BS_DEB_UP;
                    end else if (hold_c >= CMP_W'(cfg.long_press_ticks)) begin
                        ev         = '{valid: 1'b1, code: EV_LONG};
                        state_next = BS_IDLE;
                    end
                end
                BS_DEB_UP: begin
                    if (!key_level) begin
                        state_next = BS_PRESSED;
                    end else begin
                        count_next = cnt_inc;
                        if (cnt_inc >= cfg.key_debounce) begin
                            if (hold_c > CMP_W'(cfg.short_press_max_ticks)) begin
                                wait_next  = 1'b0;
                                state_next = BS_IDLE;
                            end else if (!wait_reg) begin
                                wait_next  = 1'b1;
                                gap_next   = '0;
                                state_next = BS_WAIT_DOUBLE;
                            end else if (gap_c <= CMP_W'(cfg.double_gap_ticks)) begin
                                ev         = '{valid: 1'b1, code: EV_DOUBLE};
                                wait_next  = 1'b0;
                                state_next = BS_IDLE;
                            end else begin
                                // The older click turns into a short one.
                                ev         = '{valid: 1'b1, code: EV_SHORT};
                                gap_next   = '0;
                                state_next = BS_WAIT_DOUBLE;
                            end
                        end
                    end
                end
                BS_WAIT_DOUBLE: begin
                    if (edge_down) begin
                        count_next = 4'd0;
                        state_next = BS_DEB_DOWN;
                    end else if (gap_c > CMP_W'(cfg.double_gap_ticks)) begin
                        ev         = '{valid: 1'b1, code: EV_SHORT};
                        wait_next  = 1'b0;
                        state_next = BS_IDLE;
                    end
                end
                default: begin
                    wait_next  = 1'b0;
                    state_next = BS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            count_reg <= 4'd0;
            prev_reg  <= 1'b1;
            hold_reg  <= '0;
            gap_reg   <= '0;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
            hold_reg  <= hold_next;
            gap_reg   <= gap_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

FILE: rtl/qkce_ring.sv
module qkce_ring import qkce_pkg::*; #(
    parameter int DEPTH = RING_DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             exec_en,
    input  logic             pop_en,
    input  ev_req_t          push0,
    input  ev_req_t          push1,
    output logic [2:0]       event_res,
    output logic [1:0]       dropped,
    output logic [CNT_W-1:0] count
);

    // Storage is split into two banks by slot parity so that the two events
    // of one tick land in different banks. The slot count is rounded up to
    // an even number; the logical capacity stays DEPTH - 1.
    localparam int PHYS   = DEPTH + (DEPTH % 2);
    localparam int BANK_D = PHYS / 2;
    localparam int BA_W   = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH - 1);
    localparam logic [BA_W-1:0]  BA_LAST = BA_W'(BANK_D - 1);

    logic [2:0]       bank0_mem [BANK_D];
    logic [2:0]       bank1_mem [BANK_D];
    logic             wsel_reg, wsel_next;
    logic [BA_W-1:0]  waddr_reg, waddr_next;
    logic             rsel_reg, rsel_next;
    logic [BA_W-1:0]  raddr_reg, raddr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       ev_reg;
    logic [1:0]       drop_reg;
    logic             ok0, ok1;
    logic [CNT_W-1:0] cnt_mid;
    ev_req_t          first, second;
    logic             sel1;
    logic [BA_W-1:0]  addr1;
    logic             we0, we1;
    logic [BA_W-1:0]  wa0, wa1;
    logic [2:0]       wd0, wd1;
    logic             do_pop;
    logic [1:0]       drops;

    // A push is dropped when only one slot is free.
    assign ok0     = exec_en && push0.valid && (count_reg != FULL);
    assign cnt_mid = count_reg + CNT_W'(ok0);
    assign ok1     = exec_en && push1.valid && (cnt_mid != FULL);
    assign drops   = {1'b0, exec_en && push0.valid && !ok0} +
                     {1'b0, exec_en && push1.valid && !ok1};
    assign do_pop  = exec_en && pop_en && (count_reg != '0);

    always_comb begin
        first  = '{valid: 1'b0, code: EV_NONE};
        second = '{valid: 1'b0, code: EV_NONE};
        if (ok0) begin
            first  = push0;
            second = '{valid: ok1, code: push1.code};
        end else if (ok1) begin
            first = push1;
        end
    end

    // Slot after the write pointer.
    assign sel1  = ~wsel_reg;
    assign addr1 = wsel_reg ? ((waddr_reg == BA_LAST) ? '0 : waddr_reg + BA_W'(1)) : waddr_reg;

    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = waddr_reg;
        wa1 = waddr_reg;
        wd0 = first.code;
        wd1 = first.code;
        if (first.valid) begin
            if (!wsel_reg) begin
                we0 = 1'b1;
            end else begin
                we1 = 1'b1;
            end
        end
        if (second.valid) begin
            if (!sel1) begin
                we0 = 1'b1;
                wa0 = addr1;
                wd0 = second.code;
            end else begin
                we1 = 1'b1;
                wa1 = addr1;
                wd1 = second.code;
            end
        end
    end

    always_comb begin
        wsel_next  = wsel_reg;
        waddr_next = waddr_reg;
        if (first.valid && second.valid) begin
            waddr_next = (waddr_reg == BA_LAST) ? '0 : waddr_reg + BA_W'(1);
        end else if (first.valid) begin
            wsel_next  = sel1;
            waddr_next = addr1;
        end
        rsel_next  = rsel_reg;
        raddr_next = raddr_reg;
        if (do_pop) begin
            rsel_next = ~rsel_reg;
            if (rsel_reg) begin
                raddr_next = (raddr_reg == BA_LAST) ? '0 : raddr_reg + BA_W'(1);
            end
        end
        count_next = count_reg + CNT_W'(first.valid) + CNT_W'(second.valid)
                     - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsel_reg  <= 1'b0;
            waddr_reg <= '0;
            rsel_reg  <= 1'b0;
            raddr_reg <= '0;
            count_reg <= '0;
        end else begin
            wsel_reg  <= wsel_next;
            waddr_reg <= waddr_next;
            rsel_reg  <= rsel_next;
            raddr_reg <= raddr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we0) begin
            bank0_mem[wa0] <= wd0;
        end
        if (we1) begin
            bank1_mem[wa1] <= wd1;
        end
    end

    // Registered read; every executed word that is not a successful pop
    // returns no event.
    always_ff @(posedge aclk) begin
        if (exec_en) begin
            if (do_pop) begin
                ev_reg <= rsel_reg ? bank1_mem[raddr_reg] : bank0_mem[raddr_reg];
            end else begin
                ev_reg <= EV_NONE;
            end
            drop_reg <= drops;
        end
    end

    assign event_res = ev_reg;
    assign dropped   = drop_reg;
    assign count     = count_reg;

endmodule

FILE: rtl/quadrature_knob_with_click_events_top.sv
// An accepted word waits in the front queue and executes from there once the
// result register is free; the result is then held there until it is taken.
// Throughput: one word per cycle while the receiver keeps taking results.
// Reset (aresetn low at a clock edge, synchronous) empties the queue and the
// event ring, clears position and decoder state, and loads the default config.
module quadrature_knob_with_click_events_top import qkce_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [2:0]         s_pins,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_event_res,
    output logic signed [31:0] m_position,
    output logic [3:0]         m_pending,
    output logic [1:0]         m_dropped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int CNT_W = $clog2(RING_DEPTH);
    localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(RING_DEPTH - 1);

    cfg_t             cfg_reg;
    logic             q_valid;
    cmd_t             q_cmd;
    logic             fire;
    logic             m_valid_reg, m_valid_next;
    ev_req_t          quad_ev, key_ev;
    logic [CNT_W-1:0] ring_count;
    logic [CNT_W+3:0] count_ext;

    // Configuration registers. Writes are always taken; an index past the
    // last register is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_debounce         <= 4'd3;
            cfg_reg.key_debounce          <= 4'd2;
            cfg_reg.steps_per_detent      <= 3'd2;
            cfg_reg.long_press_ticks      <= 16'd200;
            cfg_reg.short_press_max_ticks <= 16'd160;
            cfg_reg.double_gap_ticks      <= 16'd50;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STEP_DEBOUNCE:    cfg_reg.step_debounce         <= cfg_data[3:0];
                CFG_KEY_DEBOUNCE:     cfg_reg.key_debounce          <= cfg_data[3:0];
                CFG_STEPS_PER_DETENT: cfg_reg.steps_per_detent      <= cfg_data[2:0];
                CFG_LONG_PRESS:       cfg_reg.long_press_ticks      <= cfg_data;
                CFG_SHORT_PRESS_MAX:  cfg_reg.short_press_max_ticks <= cfg_data;
                CFG_DOUBLE_GAP:       cfg_reg.double_gap_ticks      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: takes input words, decodes the opcode and parks the word in a
    // two-entry queue. The queue keeps accepting while a result waits, until full.
    qkce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_pins   (s_pins),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_take   (fire)
    );

    // Back: a word executes when the result register is empty or its word
    // is being taken in the same cycle. All state then moves at once.
    assign fire = q_valid && (!m_valid_reg || m_ready);

    // Quadrature decoder and position counter.
    qkce_quad u_quad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick_en  (fire && q_cmd.tick),
        .zero_en  (fire && q_cmd.zero),
        .phases   (q_cmd.pins[2:1]),
        .cfg      (cfg_reg),
        .ev       (quad_ev),
        .position (m_position)
    );

    // Key debouncer and click classifier.
    qkce_button #(
        .TIMER_BITS (TIMER_BITS)
    ) u_button (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (fire && q_cmd.tick),
        .key_level (q_cmd.pins[0]),
        .cfg       (cfg_reg),
        .ev        (key_ev)
    );

    // Event ring. The rotation event of a tick goes in ahead of the key event.
    qkce_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .exec_en   (fire),
        .pop_en    (q_cmd.pop),
        .push0     (quad_ev),
        .push1     (key_ev),
        .event_res (m_event_res),
        .dropped   (m_dropped),
        .count     (ring_count)
    );

    // Position and pending count are the live state registers; they only
    // change when a word executes, which needs the result slot to be free,
    // so they hold the result of the last word while it waits.
    assign count_ext = (CNT_W + 4)'(ring_count);
    assign m_pending = count_ext[3:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // The ring always keeps one slot empty.
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_count <= RING_FULL)
        else $error("event ring holds more than its capacity");

    // A dropped event means the ring was left full by that word.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dropped != 2'd0) |-> (ring_count == RING_FULL))
        else $error("event dropped while the ring had room");

    // A new result only appears after a queued word was executed.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(q_valid))
        else $error("result raised without a queued word");
`endif

endmodule

FILE: dv/quadrature_knob_with_click_events_top_tb.sv
`timescale 1ns / 1ps

module quadrature_knob_with_click_events_top_tb;
    import qkce_pkg::*;

    // Opcode 3 has no operation behind it; the block must leave all state alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WORDS_PER_PHASE = 130;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] pins;
    } knob_word_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] pos;
        logic [3:0]  pend;
        logic [1:0]  drop;
    } knob_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_TICK;
    logic [2:0]  s_pins = 3'b001;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic signed [31:0] m_position;
    logic [3:0]  m_pending;
    logic [1:0]  m_dropped;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_STEP_DEBOUNCE;
    logic [15:0] cfg_data = 16'd0;

    quadrature_knob_with_click_events_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_pins(s_pins),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_event_res(m_event_res),
        .m_position(m_position),
        .m_pending(m_pending),
        .m_dropped(m_dropped),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // Words waiting to be driven, and the reports the knob should produce for
    // the words it has already taken, oldest first.
    knob_word_t   knob_words[$];
    knob_report_t expected_reports[$];

    // Percent chances of the sender holding back and the receiver stalling.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatches = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int drop_ticks = 0;
    int cycle_count = 0;
    int ev_seen[8];

    // Shadow copy of the knob: configuration first, then decoder, button and ring.
    logic [3:0]  c_step_deb = 4'd3;
    logic [3:0]  c_key_deb = 4'd2;
    logic [2:0]  c_spd = 3'd2;
    logic [15:0] c_long = 16'd200;
    logic [15:0] c_short = 16'd160;
    logic [15:0] c_gap = 16'd50;

    logic [3:0]  k_step_cnt = 4'd0;
    logic [1:0]  k_phase = 2'b00;
    int          k_detent = 0;
    logic [31:0] k_pos = 32'd0;
    btn_state_t  k_btn = BS_IDLE;
    logic [3:0]  k_btn_cnt = 4'd0;
    logic        k_prev_key = 1'b1;
    logic [15:0] k_hold = 16'd0;
    logic        k_waiting = 1'b0;
    logic [15:0] k_gap = 16'd0;
    logic [2:0]  k_ring[16];
    logic [3:0]  k_head = 4'd0;
    logic [3:0]  k_tail = 4'd0;
    int          k_drops = 0;

    // Pin levels the stimulus generator is currently presenting.
    logic [1:0]  g_phase = 2'b00;
    logic        g_key = 1'b1;

    knob_word_t   drive_word;
    knob_report_t predicted;
    knob_report_t oldest;

    // One clockwise step through the Gray sequence 00, 01, 11, 10.
    function automatic logic [1:0] cw_next(input logic [1:0] ph);
        case (ph)
            2'b00: return 2'b01;
            2'b01: return 2'b11;
            2'b11: return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] ccw_next(input logic [1:0] ph);
        return cw_next(cw_next(cw_next(ph)));
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // The ring always keeps one slot free, so at most 15 events can wait.
    task automatic push_event(input logic [2:0] code);
        logic [3:0] nxt;
        nxt = k_head + 4'd1;
        if (nxt == k_tail) begin
            k_drops++;
        end else begin
            k_ring[k_head] = code;
            k_head = nxt;
        end
    endtask

    task automatic decode_phases(input logic [1:0] cur);
        logic [4:0] cnt;
        int dir;
        int spd;
        cnt = {1'b0, k_step_cnt} + 5'd1;
        spd = (c_spd == 3'd0) ? 1 : int'(c_spd);
        if (cw_next(k_phase) == cur) dir = 1;
        else if (cw_next(cur) == k_phase) dir = -1;
        else dir = 0;

        if (dir == 0) begin
            // Holding still builds the count up; a jump by two phases wipes it.
            if (cur == k_phase)
                k_step_cnt = (cnt >= {1'b0, c_step_deb}) ? c_step_deb : cnt[3:0];
            else
                k_step_cnt = 4'd0;
        end else if (cnt < {1'b0, c_step_deb}) begin
            k_step_cnt = cnt[3:0];
        end else begin
            k_pos = k_pos + ((dir > 0) ? 32'd1 : 32'hFFFF_FFFF);
            k_phase = cur;
            k_detent = k_detent + dir;
            if (k_detent >= spd) begin
                push_event(EV_CW);
                k_detent = k_detent - spd;
            end else if (k_detent <= -spd) begin
                push_event(EV_CCW);
                k_detent = k_detent + spd;
            end
            k_step_cnt = 4'd0;
        end
    endtask

    task automatic classify_key(input logic lvl);
        logic edge_dn;
        edge_dn = k_prev_key && !lvl;
        k_prev_key = lvl;
        if (k_btn == BS_PRESSED || k_btn == BS_DEB_UP) k_hold = sat16(k_hold);
        if (k_waiting) k_gap = sat16(k_gap);

        case (k_btn)
            BS_IDLE: begin
                if (edge_dn) begin
                    k_btn_cnt = 4'd0;
                    k_btn = BS_DEB_DOWN;
                end
            end
            BS_DEB_DOWN: begin
                if (!lvl) begin
                    k_btn_cnt = k_btn_cnt + 4'd1;
                    if (k_btn_cnt >= c_key_deb) begin
                        k_hold = 16'd0;
                        k_btn = BS_PRESSED;
                    end
                end else begin
                    k_btn = BS_IDLE;
                end
            end
            BS_PRESSED: begin
                if (lvl) begin
                    k_btn_cnt = 4'd0;
                    k_btn = BS_DEB_UP;
                end else if (k_hold >= c_long) begin
                    push_event(EV_LONG);
                    k_btn = BS_IDLE;
                end
            end
            BS_DEB_UP: begin
                if (!lvl) begin
                    k_btn = BS_PRESSED;
                end else begin
                    k_btn_cnt = k_btn_cnt + 4'd1;
                    if (k_btn_cnt >= c_key_deb) begin
                        if (k_hold > c_short) begin
                            k_waiting = 1'b0;
                            k_btn = BS_IDLE;
                        end else if (!k_waiting) begin
                            k_waiting = 1'b1;
                            k_gap = 16'd0;
                            k_btn = BS_WAIT_DOUBLE;
                        end else if (k_gap <= c_gap) begin
                            push_event(EV_DOUBLE);
                            k_waiting = 1'b0;
                            k_btn = BS_IDLE;
                        end else begin
                            // The old click was too long ago: it goes out as a
                            // short click and this one starts a new wait.
                            push_event(EV_SHORT);
                            k_gap = 16'd0;
                            k_btn = BS_WAIT_DOUBLE;
                        end
                    end
                end
            end
            BS_WAIT_DOUBLE: begin
                if (edge_dn) begin
                    k_btn_cnt = 4'd0;
                    k_btn = BS_DEB_DOWN;
                end else if (k_gap > c_gap) begin
                    push_event(EV_SHORT);
                    k_waiting = 1'b0;
                    k_btn = BS_IDLE;
                end
            end
            default: begin
                k_btn = BS_IDLE;
                k_waiting = 1'b0;
            end
        endcase
    endtask

    // Works out the report the knob owes for one accepted word.
    task automatic knob_predict(input logic [1:0] op, input logic [2:0] pins,
                                output knob_report_t rep);
        logic [2:0] ev;
        ev = EV_NONE;
        k_drops = 0;
        case (op)
            OP_TICK: begin
                decode_phases(pins[2:1]);
                classify_key(pins[0]);
            end
            OP_POP: begin
                if (k_tail != k_head) begin
                    ev = k_ring[k_tail];
                    k_tail = k_tail + 4'd1;
                end
            end
            OP_ZERO: k_pos = 32'd0;
            default: ;
        endcase
        rep.ev = ev;
        rep.pos = k_pos;
        rep.pend = k_head - k_tail;
        rep.drop = k_drops[1:0];
    endtask

    task automatic apply_config(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_STEP_DEBOUNCE:    c_step_deb = val[3:0];
            CFG_KEY_DEBOUNCE:     c_key_deb = val[3:0];
            CFG_STEPS_PER_DETENT: c_spd = val[2:0];
            CFG_LONG_PRESS:       c_long = val;
            CFG_SHORT_PRESS_MAX:  c_short = val;
            CFG_DOUBLE_GAP:       c_gap = val;
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d want %0d",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // Driver: the word on the bus is taken when valid and ready meet at an edge.
    // Its prediction is made right then, so the shadow state advances in the
    // same order as the knob's own. A new word is offered only once the old one
    // is gone, which keeps valid and the payload steady while the knob stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                knob_predict(s_opcode, s_pins, predicted);
                expected_reports.push_back(predicted);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (knob_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_word = knob_words.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= drive_word.op;
                    s_pins <= drive_word.pins;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every report taken from the knob is checked against the oldest
    // prediction, field by field.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    flag_mismatch("report with nothing outstanding, event", m_event_res, -1);
                end else begin
                    oldest = expected_reports.pop_front();
                    if (m_event_res !== oldest.ev)
                        flag_mismatch("event_res", m_event_res, oldest.ev);
                    if (m_position !== oldest.pos)
                        flag_mismatch("position", m_position, $signed(oldest.pos));
                    if (m_pending !== oldest.pend)
                        flag_mismatch("pending", m_pending, oldest.pend);
                    if (m_dropped !== oldest.drop)
                        flag_mismatch("dropped", m_dropped, oldest.drop);
                    ev_seen[oldest.ev]++;
                    if (oldest.drop != 2'd0) drop_ticks++;
                end
                results_checked++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus building blocks. Each one appends words for the current pin
    // levels, so the generator can play a knob being turned and pressed.
    task automatic add_word(input logic [1:0] op, input logic [2:0] pins);
        knob_words.push_back('{op: op, pins: pins});
    endtask

    task automatic ticks(input int n);
        repeat (n) add_word(OP_TICK, {g_phase, g_key});
    endtask

    // A hold of zero picks a random dwell per step; now and then the dwell is
    // too short, which the decoder should treat as contact bounce.
    task automatic turn(input logic cw, input int steps, input int hold);
        int h;
        for (int i = 0; i < steps; i++) begin
            g_phase = cw ? cw_next(g_phase) : ccw_next(g_phase);
            h = hold;
            if (h == 0) begin
                h = int'(c_step_deb) + int'($urandom_range(1));
                if ($urandom_range(5) == 0) h = int'($urandom_range(int'(c_step_deb), 1));
            end
            ticks(h);
        end
    endtask

    task automatic click(input int press_extra, input int release_extra);
        g_key = 1'b0;
        ticks(int'(c_key_deb) + press_extra);
        g_key = 1'b1;
        ticks(int'(c_key_deb) + release_extra);
    endtask

    task automatic random_activity();
        int pick;
        int cap_p;
        int cap_r;
        logic [1:0] op;
        logic [2:0] pins;
        pick = int'($urandom_range(99));
        cap_p = (int'(c_long) + 2 > 24) ? 24 : int'(c_long) + 2;
        cap_r = (int'(c_gap) + 3 > 24) ? 24 : int'(c_gap) + 3;
        if (pick < 35) begin
            turn(1'($urandom_range(1)), int'($urandom_range(6, 1)), 0);
        end else if (pick < 60) begin
            click(int'($urandom_range(cap_p)), int'($urandom_range(cap_r)));
        end else if (pick < 68) begin
            // Two quick clicks, aimed at the double-click window.
            click(int'($urandom_range(3)), int'($urandom_range(3)));
            click(int'($urandom_range(3)), int'($urandom_range(cap_r)));
        end else if (pick < 80) begin
            repeat ($urandom_range(4, 1)) add_word(OP_POP, 3'($urandom_range(7)));
        end else if (pick < 84) begin
            add_word(OP_ZERO, 3'($urandom_range(7)));
        end else begin
            // Noise: any opcode, any pins. Pins on a tick become the new levels.
            repeat ($urandom_range(4, 1)) begin
                op = 2'($urandom_range(3));
                pins = 3'($urandom_range(7));
                add_word(op, pins);
                if (op == OP_TICK) begin
                    g_phase = pins[2:1];
                    g_key = pins[0];
                end
            end
        end
        if ($urandom_range(9) < 3) add_word(OP_POP, 3'($urandom_range(7)));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_config(idx, val);
    endtask

    // Waits until every word has been taken and every report checked, so that the
    // pipeline is surely empty before a config write.
    task automatic settle();
        while (knob_words.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] v_step;
        logic [15:0] v_key;
        logic [15:0] v_spd;
        logic [15:0] v_long;
        logic [15:0] v_short;
        logic [15:0] v_gap;

        for (int i = 0; i < 8; i++) ev_seen[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening on the reset configuration: pop of an empty ring,
        // the unused opcode, a clockwise detent, a jump by two phases, a
        // counterclockwise turn, one click, then zeroing between pops.
        add_word(OP_POP, 3'b111);
        add_word(OP_UNUSED, 3'b000);
        ticks(1);
        turn(1'b1, 2, 3);
        g_phase = g_phase ^ 2'b11;
        ticks(2);
        turn(1'b0, 2, 0);
        click(0, 0);
        add_word(OP_POP, 3'b010);
        add_word(OP_ZERO, 3'b101);
        add_word(OP_POP, 3'b000);
        settle();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: begin
                    v_step = 16'd1; v_key = 16'd1; v_spd = 16'd1;
                    v_long = 16'd6; v_short = 16'd3; v_gap = 16'd4;
                end
                2: begin
                    v_step = 16'd15; v_key = 16'd15; v_spd = 16'd4;
                    v_long = 16'd40; v_short = 16'd20; v_gap = 16'd12;
                end
                3: begin
                    // Zero steps per detent acts as one; a long press of one tick
                    // and a zero short limit leave no room for clicks.
                    v_step = 16'd2; v_key = 16'd3; v_spd = 16'd0;
                    v_long = 16'd1; v_short = 16'd0; v_gap = 16'd0;
                end
                4: begin
                    v_step = 16'd3; v_key = 16'd2; v_spd = 16'd3;
                    v_long = 16'hFFFF; v_short = 16'hFFFF; v_gap = 16'hFFFF;
                end
                5: begin
                    v_step = 16'd4; v_key = 16'd4; v_spd = 16'd2;
                    v_long = 16'd25; v_short = 16'd12; v_gap = 16'd8;
                end
                default: begin
                    v_step = 16'($urandom_range(15, 1));
                    v_key = 16'($urandom_range(15, 1));
                    v_spd = 16'($urandom_range(4));
                    v_long = 16'($urandom_range(60, 1));
                    v_short = 16'($urandom_range(40));
                    v_gap = 16'($urandom_range(30));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            cfg_write(CFG_STEP_DEBOUNCE, v_step);
            cfg_write(CFG_KEY_DEBOUNCE, v_key);
            cfg_write(CFG_STEPS_PER_DETENT, v_spd);
            cfg_write(CFG_LONG_PRESS, v_long);
            cfg_write(CFG_SHORT_PRESS_MAX, v_short);
            cfg_write(CFG_DOUBLE_GAP, v_gap);

            if (ph == 1) begin
                // With one-tick debounce every tick is a detent. Sixteen of them
                // overfill the ring; a long press during further spinning makes
                // the decoder and the button lose an event in the same tick.
                turn(1'b1, 16, 1);
                g_key = 1'b0;
                turn(1'b1, 12, 1);
                g_key = 1'b1;
                ticks(3);
                repeat (16) add_word(OP_POP, 3'($urandom_range(7)));
            end
            while (knob_words.size() < WORDS_PER_PHASE) random_activity();
            settle();
        end

        $display("checked %0d reports from %0d words over seven configuration settings",
                 results_checked, words_accepted);
        $display("events popped: cw %0d ccw %0d short %0d long %0d double %0d, lossy ticks %0d",
                 ev_seen[EV_CW], ev_seen[EV_CCW], ev_seen[EV_SHORT], ev_seen[EV_LONG],
                 ev_seen[EV_DOUBLE], drop_ticks);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
